>>> hw/rtl/point_set_diameter_and_force_sum_macros.svh
// ----------------------------------------------------------------------------
// Point set diameter and force sum: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef POINT_SET_DIAMETER_AND_FORCE_SUM_MACROS_SVH
`define POINT_SET_DIAMETER_AND_FORCE_SUM_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define PSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Widths and defaults shared by the point set diameter block and its checker.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int MAX_POINTS_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int FORCE_W = 16;
  localparam int FSUM_W  = 20;
  localparam int FMAG_W  = 21;

endpackage

>>> hw/rtl/psd_isqrt.sv
// ----------------------------------------------------------------------------
// psd_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module psd_isqrt #(
  parameter int IN_W = 42
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [IN_W-1:0]     operand,
  output logic                done,
  output logic [IN_W/2-1:0]   root
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 3;
  localparam int CNT_W = $clog2(OUT_W + 1);

  logic [IN_W-1:0]  op;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             running;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  assign rem_sh = {rem[REM_W-3:0], op[IN_W-1:IN_W-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(OUT_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= operand;
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      op   <= {op[IN_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[OUT_W-2:0], fits};
    end
  end

endmodule

>>> hw/rtl/point_set_diameter_and_force_sum.sv
// ----------------------------------------------------------------------------
// point_set_diameter_and_force_sum
// Largest pairwise distance of a 2D point set, plus force totals and magnitude.
// ----------------------------------------------------------------------------
// Usage: drive pos_x, pos_y, force_x, force_y and last_point with start high;
// the beat is taken on a clock edge where start is high and busy is low.
// Positions go into a one-read, one-write point memory. A new point is
// compared with the n points already stored, one memory read per cycle,
// through a read / difference / square / compare pipeline, then written.
// With n from 1 to MAX_POINTS - 1, busy covers n reads, a drain of the
// pipeline and one write; the first point of a set only takes the write.
// The memory read port sets this pace. Beyond MAX_POINTS points, busy stays
// low unless last_point is set, and an item only adds to the force totals.
// On a beat with last_point set, the shared square-root unit runs twice
// (distance, then force magnitude), one root bit per cycle over a 21-bit root
// at the default widths. The result appears for one cycle with done high,
// then the block clears its counters and sums and drops busy.
// The receiver cannot stall; done is a one-cycle strobe.
// Reset (rst, synchronous) clears the count, sums and flags; the point memory
// is not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module point_set_diameter_and_force_sum #(
  parameter int MAX_POINTS  = psd_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       pos_x,
  input  logic signed [COORD_WIDTH-1:0]       pos_y,
  input  logic [psd_pkg::FORCE_W-1:0]         force_x,
  input  logic [psd_pkg::FORCE_W-1:0]         force_y,
  input  logic                                last_point,
  output logic                                done,
  output logic [COORD_WIDTH:0]                max_distance,
  output logic [psd_pkg::FSUM_W-1:0]          total_fx,
  output logic [psd_pkg::FSUM_W-1:0]          total_fy,
  output logic [psd_pkg::FMAG_W-1:0]          force_magnitude,
  output logic [$clog2(MAX_POINTS+1)-1:0]     points_seen,
  output logic                                overflow
);

  localparam int CW      = COORD_WIDTH;
  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W  = CW + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int D2_W    = SQ_W + 1;
  localparam int FSUM_W  = psd_pkg::FSUM_W;
  localparam int FMAG_W  = psd_pkg::FMAG_W;
  localparam int FSQ_W   = 2 * FSUM_W;
  localparam int RT_RAW  = (D2_W > FSQ_W + 1) ? D2_W : FSQ_W + 1;
  localparam int RT_IN_W = RT_RAW + (RT_RAW % 2);
  localparam int RT_OUT_W = RT_IN_W / 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_STORE  = 4'd3;
  localparam logic [3:0] S_ROOT_D = 4'd4;
  localparam logic [3:0] S_WAIT_D = 4'd5;
  localparam logic [3:0] S_ROOT_F = 4'd6;
  localparam logic [3:0] S_WAIT_F = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]        state;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  count;
  logic              overflow_q;
  logic              last_q;
  logic [FSUM_W-1:0] sum_fx;
  logic [FSUM_W-1:0] sum_fy;
  logic [D2_W-1:0]   max_d2;

  logic signed [CW-1:0] cur_x;
  logic signed [CW-1:0] cur_y;

  logic [2*CW-1:0]   pt_mem [MAX_POINTS];
  logic [2*CW-1:0]   rd_data;
  logic              rd_v;

  logic [DIFF_W-1:0] dx;
  logic [DIFF_W-1:0] dy;
  logic              dv;
  logic [SQ_W-1:0]   sqx;
  logic [SQ_W-1:0]   sqy;
  logic              sv;

  logic [FSQ_W-1:0]  fsq_x;
  logic [FSQ_W-1:0]  fsq_y;
  logic [CW:0]       dist_root;
  logic [FMAG_W-1:0] fmag;

  logic                rt_start;
  logic [RT_IN_W-1:0]  rt_operand;
  logic                rt_done;
  logic [RT_OUT_W-1:0] rt_root;

  logic                accept;
  logic [FSUM_W:0]     fx_add;
  logic [FSUM_W:0]     fy_add;
  logic signed [DIFF_W-1:0] ddx;
  logic signed [DIFF_W-1:0] ddy;
  logic [D2_W-1:0]     d2;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign fx_add = {1'b0, sum_fx} + (FSUM_W+1)'(force_x);
  assign fy_add = {1'b0, sum_fy} + (FSUM_W+1)'(force_y);

  assign ddx = {cur_x[CW-1], cur_x} - {rd_data[2*CW-1], rd_data[2*CW-1:CW]};
  assign ddy = {cur_y[CW-1], cur_y} - {rd_data[CW-1], rd_data[CW-1:0]};
  assign d2  = {1'b0, sqx} + {1'b0, sqy};

  // point memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      pt_mem[count[IDX_W-1:0]] <= {cur_x, cur_y};
    end
    rd_data <= pt_mem[rd_idx];
  end

  // distance pipeline payload
  always_ff @(posedge clk) begin
    dx  <= ddx[DIFF_W-1] ? DIFF_W'(-ddx) : DIFF_W'(ddx);
    dy  <= ddy[DIFF_W-1] ? DIFF_W'(-ddy) : DIFF_W'(ddy);
    sqx <= dx * dx;
    sqy <= dy * dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      dv   <= 1'b0;
      sv   <= 1'b0;
    end else begin
      rd_v <= (state == S_SCAN);
      dv   <= rd_v;
      sv   <= dv;
    end
  end

  // item payload and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x <= pos_x;
      cur_y <= pos_y;
    end
    if (state == S_ROOT_D) begin
      fsq_x <= sum_fx * sum_fx;
      fsq_y <= sum_fy * sum_fy;
    end
    if (state == S_WAIT_D && rt_done) begin
      dist_root <= rt_root[CW:0];
    end
    if (state == S_WAIT_F && rt_done) begin
      fmag <= rt_root[FMAG_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_idx     <= '0;
      count      <= '0;
      overflow_q <= 1'b0;
      last_q     <= 1'b0;
      sum_fx     <= '0;
      sum_fy     <= '0;
      max_d2     <= '0;
    end else begin
      if (sv && (d2 > max_d2)) begin
        max_d2 <= d2;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= last_point;
            sum_fx <= fx_add[FSUM_W] ? '1 : fx_add[FSUM_W-1:0];
            sum_fy <= fy_add[FSUM_W] ? '1 : fy_add[FSUM_W-1:0];
            rd_idx <= '0;
            if (count == CNT_W'(MAX_POINTS)) begin
              overflow_q <= 1'b1;
              state      <= last_point ? S_ROOT_D : S_IDLE;
            end else if (count == '0) begin
              state <= S_STORE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_idx <= rd_idx + IDX_W'(1);
          if (CNT_W'(rd_idx) == count - CNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !dv && !sv) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          count <= count + CNT_W'(1);
          state <= last_q ? S_ROOT_D : S_IDLE;
        end
        S_ROOT_D: begin
          state <= S_WAIT_D;
        end
        S_WAIT_D: begin
          if (rt_done) begin
            state <= S_ROOT_F;
          end
        end
        S_ROOT_F: begin
          state <= S_WAIT_F;
        end
        S_WAIT_F: begin
          if (rt_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          count      <= '0;
          overflow_q <= 1'b0;
          sum_fx     <= '0;
          sum_fy     <= '0;
          max_d2     <= '0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rt_start   = (state == S_ROOT_D) || (state == S_ROOT_F);
  assign rt_operand = (state == S_ROOT_D) ? RT_IN_W'(max_d2)
                                          : RT_IN_W'(fsq_x) + RT_IN_W'(fsq_y);

  psd_isqrt #(
    .IN_W (RT_IN_W)
  ) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (rt_start),
    .operand (rt_operand),
    .done    (rt_done),
    .root    (rt_root)
  );

  assign done            = (state == S_OUT);
  assign max_distance    = dist_root;
  assign total_fx        = sum_fx;
  assign total_fy        = sum_fy;
  assign force_magnitude = fmag;
  assign points_seen     = count;
  assign overflow        = overflow_q;

endmodule

>>> hw/rtl/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the point set diameter block, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_set_diameter_and_force_sum_macros.svh"

module psd_checker #(
  parameter int MAX_POINTS  = psd_pkg::MAX_POINTS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                last_point,
  input logic                                done,
  input logic [psd_pkg::FSUM_W-1:0]          total_fx,
  input logic [psd_pkg::FMAG_W-1:0]          force_magnitude,
  input logic [$clog2(MAX_POINTS+1)-1:0]     points_seen,
  input logic                                overflow
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int FMAG_W = psd_pkg::FMAG_W;

  `PSD_ASSERT_NOW(a_done_busy, done, busy, "result beat while not busy")
  `PSD_ASSERT_NEXT(a_done_idle, done, !busy, "busy held after result beat")
  `PSD_ASSERT_NEXT(a_no_early_result, start && !busy && !last_point, !done,
    "result beat right after a non-final beat")
  `PSD_ASSERT_NOW(a_overflow_full, done && overflow, points_seen == CNT_W'(MAX_POINTS),
    "overflow flagged with store not full")
  `PSD_ASSERT_NOW(a_magnitude_bound, done, force_magnitude >= FMAG_W'(total_fx),
    "force magnitude below x total")

endmodule

bind point_set_diameter_and_force_sum psd_checker #(
  .MAX_POINTS  (MAX_POINTS)
) u_psd_checker (.*);
